// ----- sv/gnnp_pkg.sv -----
// ----------------------------------------------------------------------------
// gnnp_pkg: shared types for the greedy nearest-neighbor path builder
// Holds the word formats passed between the loader, queue and path engine.
// ----------------------------------------------------------------------------
package gnnp_pkg;

  localparam int IDX_W = 5;

  // One load command handed from the front end to the path engine.
  typedef struct packed {
    logic        store_en;
    logic        last;
    logic [31:0] x;
    logic [31:0] y;
  } load_cmd_t;

endpackage

// ----- sv/gnnp_front.sv -----
// ----------------------------------------------------------------------------
// gnnp_front: input word intake
// Takes input words, sign-extends coordinates and decides whether each
// point fits in the store, then pushes one command per word into the queue.
// ----------------------------------------------------------------------------
module gnnp_front #(
  parameter int MAX_POINTS = 32,
  parameter int COORD_BITS = 16,
  parameter int CNT_W      = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,
  input  logic                  in_tlast,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output gnnp_pkg::load_cmd_t   cmd
);

  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             acc;

  assign in_tready = cmd_ready;
  assign cmd_valid = in_tvalid;
  assign acc       = in_tvalid & cmd_ready;

  always_comb begin
    cmd.store_en = (fill_r < CNT_W'(MAX_POINTS));
    cmd.last     = in_tlast;
    cmd.x        = 32'(signed'(in_tdata[COORD_BITS-1:0]));
    cmd.y        = 32'(signed'(in_tdata[16+COORD_BITS-1:16]));
    fill_nxt     = fill_r;
    if (acc) begin
      if (in_tlast) begin
        fill_nxt = '0;
      end else if (cmd.store_en) begin
        fill_nxt = fill_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

endmodule

// ----- sv/gnnp_queue.sv -----
// ----------------------------------------------------------------------------
// gnnp_queue: command queue
// A two-entry queue that lets the front end run ahead of the path engine.
// ----------------------------------------------------------------------------
module gnnp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  gnnp_pkg::load_cmd_t wr_data,
  output logic                rd_valid,
  input  logic                rd_ready,
  output gnnp_pkg::load_cmd_t rd_data
);

  gnnp_pkg::load_cmd_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr       = wr_valid & wr_ready;
  assign rd       = rd_valid & rd_ready;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

// ----- sv/gnnp_engine.sv -----
// ----------------------------------------------------------------------------
// gnnp_engine: point store and path engine
// Stores points and, on the last point, walks the greedy path: one point
// compared per cycle through a registered squaring stage.
// ----------------------------------------------------------------------------
module gnnp_engine #(
  parameter int MAX_POINTS = 32,
  parameter int COORD_BITS = 16,
  parameter int CNT_W      = 7,
  parameter int PTR_W      = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  gnnp_pkg::load_cmd_t cmd,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_tdata,
  output logic                out_tlast
);

  localparam int DW = 2 * COORD_BITS + 2;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;

  logic signed [COORD_BITS-1:0] xs_r [MAX_POINTS];
  logic signed [COORD_BITS-1:0] ys_r [MAX_POINTS];
  logic [MAX_POINTS-1:0] vis_r;
  logic [2:0]       st_r;
  logic [CNT_W-1:0] cnt_r, links_r;
  logic             ovf_r;
  logic [CNT_W-1:0] i_r;
  logic [PTR_W-1:0] cur_r, best_r;
  logic signed [COORD_BITS-1:0] curx_r, cury_r, bestx_r;
  logic [DW-1:0]    bestd_r;
  logic             have_r;
  // squaring stage
  logic             p_v_r;
  logic [PTR_W-1:0] p_i_r;
  logic signed [COORD_BITS-1:0] p_x_r;
  logic [2*COORD_BITS-1:0] sqx_r, sqy_r;
  logic             o_v_r, o_last_r, o_ovf_r;
  logic [PTR_W-1:0] o_from_r, o_to_r;

  logic [PTR_W-1:0]  ii;
  logic signed [COORD_BITS:0] dx, dy;
  logic [COORD_BITS:0] ax, ay;
  logic [DW-1:0]     d;
  logic              better;

  assign ii  = i_r[PTR_W-1:0];
  assign dx  = (COORD_BITS+1)'(xs_r[ii]) - (COORD_BITS+1)'(curx_r);
  assign dy  = (COORD_BITS+1)'(ys_r[ii]) - (COORD_BITS+1)'(cury_r);
  assign ax  = dx[COORD_BITS] ? -dx : dx;
  assign ay  = dy[COORD_BITS] ? -dy : dy;
  assign d   = DW'(sqx_r) + DW'(sqy_r);
  assign better = !have_r || d < bestd_r || (d == bestd_r && p_x_r < bestx_r);

  assign cmd_ready  = (st_r == S_LOAD);
  assign out_tvalid = o_v_r;
  assign out_tlast  = o_last_r;
  // out_tdata: from_index[4:0], to_index[9:5], overflow_flag[10], pad
  assign out_tdata  = {5'd0, o_ovf_r, o_to_r[4:0], o_from_r[4:0]};

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready && cmd.store_en) begin
      xs_r[cnt_r[PTR_W-1:0]] <= cmd.x[COORD_BITS-1:0];
      ys_r[cnt_r[PTR_W-1:0]] <= cmd.y[COORD_BITS-1:0];
    end
    p_i_r <= ii;
    p_x_r <= xs_r[ii];
    sqx_r <= (2*COORD_BITS)'(ax * ax);
    sqy_r <= (2*COORD_BITS)'(ay * ay);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD; cnt_r <= '0; ovf_r <= 1'b0; o_v_r <= 1'b0;
      p_v_r <= 1'b0; vis_r <= '0; have_r <= 1'b0;
    end else begin
      if (st_r == S_EMIT && (!o_v_r || out_tready)) o_v_r <= 1'b1;
      else if (out_tready) o_v_r <= 1'b0;
      p_v_r <= (st_r == S_SCAN) && (i_r != cnt_r) && !vis_r[ii];
      case (st_r)
        S_LOAD: begin
          if (cmd_valid) begin
            if (cmd.store_en) cnt_r <= cnt_r + CNT_W'(1);
            else ovf_r <= 1'b1;
            if (cmd.last) begin
              st_r   <= S_START;
              i_r    <= '0;
              best_r <= '0;
            end
          end
        end
        S_START: begin
          // Leftmost point search; strict compare keeps the lower index.
          if (i_r == cnt_r) begin
            if (cnt_r < CNT_W'(2)) begin
              st_r <= S_LOAD; cnt_r <= '0; ovf_r <= 1'b0;
            end else begin
              cur_r   <= best_r;
              curx_r  <= xs_r[best_r];
              cury_r  <= ys_r[best_r];
              vis_r   <= MAX_POINTS'(1) << best_r;
              links_r <= cnt_r - CNT_W'(1);
              i_r     <= '0;
              have_r  <= 1'b0;
              st_r    <= S_SCAN;
            end
          end else begin
            if (xs_r[ii] < xs_r[best_r]) best_r <= ii;
            i_r <= i_r + CNT_W'(1);
          end
        end
        S_SCAN: begin
          if (i_r != cnt_r) begin
            i_r   <= i_r + CNT_W'(1);
          end
          if (p_v_r && better) begin
            have_r  <= 1'b1;
            best_r  <= p_i_r;
            bestd_r <= d;
            bestx_r <= p_x_r;
          end
          if (i_r == cnt_r && !p_v_r) st_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!o_v_r || out_tready) begin
            o_from_r <= cur_r;
            o_to_r   <= best_r;
            o_ovf_r  <= ovf_r;
            o_last_r <= (links_r == CNT_W'(1));
            vis_r[best_r] <= 1'b1;
            cur_r    <= best_r;
            curx_r   <= xs_r[best_r];
            cury_r   <= ys_r[best_r];
            links_r  <= links_r - CNT_W'(1);
            i_r      <= '0;
            have_r   <= 1'b0;
            if (links_r == CNT_W'(1)) begin
              st_r <= S_WAIT;
            end else begin
              st_r <= S_SCAN;
            end
          end
        end
        S_WAIT: begin
          cnt_r <= '0; ovf_r <= 1'b0; st_r <= S_LOAD;
        end
        default: st_r <= S_LOAD;
      endcase
    end
  end

endmodule

// ----- sv/greedy_nearest_neighbor_path.sv -----
// Loading: one word per cycle while no build runs, no result; the word is queued
// and stored. Build on the last word: the single distance unit checks one stored
// point per cycle. Segments appear one per link through an output register.
// Reset (rst_n low, synchronous) empties the point set and the queue.
// ----------------------------------------------------------------------------
// greedy_nearest_neighbor_path: greedy nearest-neighbor path builder
// Loads 2D points and emits the greedy nearest-neighbor path as segments.
// ----------------------------------------------------------------------------
module greedy_nearest_neighbor_path #(
  parameter int MAX_POINTS = 32,
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // x_coord[15:0], y_coord[31:16]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // from_index[4:0], to_index[9:5], overflow_flag[10]
  output logic        out_tlast
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1) + 1;
  localparam int PTR_W = $clog2(MAX_POINTS);

  gnnp_pkg::load_cmd_t f_cmd, q_cmd;
  logic f_v, f_r, q_v, q_r;

  gnnp_front #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS), .CNT_W(CNT_W)) u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .cmd_valid(f_v), .cmd_ready(f_r), .cmd(f_cmd)
  );

  gnnp_queue u_queue (
    .clk, .rst_n, .wr_valid(f_v), .wr_ready(f_r), .wr_data(f_cmd),
    .rd_valid(q_v), .rd_ready(q_r), .rd_data(q_cmd)
  );

  gnnp_engine #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS), .CNT_W(CNT_W),
                .PTR_W(PTR_W)) u_engine (
    .clk, .rst_n, .cmd_valid(q_v), .cmd_ready(q_r), .cmd(q_cmd),
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

endmodule

// ----- dv/tb_greedy_nearest_neighbor_path.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_greedy_nearest_neighbor_path: stream testbench for the path builder
// Sends point sets of random and corner-case shape, predicts the greedy
// nearest-neighbor segments and checks every output word in order.
// ----------------------------------------------------------------------------
module tb_greedy_nearest_neighbor_path;

  localparam int CAPACITY = 32;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
  } point_t;

  typedef struct packed {
    logic [4:0] from_idx;
    logic [4:0] to_idx;
    logic       ovf;
    logic       last_seg;
  } segment_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // x_coord[15:0], y_coord[31:16]
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // from_index[4:0], to_index[9:5], overflow_flag[10]
  logic        out_tlast;

  greedy_nearest_neighbor_path dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  point_t   pending_points[$];
  segment_t expected_segments[$];

  // Predictor state: the point set gathered so far.
  logic signed [15:0] set_x[CAPACITY];
  logic signed [15:0] set_y[CAPACITY];
  int  set_count;
  bit  set_overflow;

  int  errors;
  int  cycles;
  int  segments_seen;
  int  sets_built;
  bit  calm_phase;
  bit  hold_request;
  int  hold_left;
  bit  stim_done;
  bit  in_fire;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic longint unsigned dist_sq(int a, int b);
    longint dx, dy;
    dx = longint'(set_x[a]) - longint'(set_x[b]);
    dy = longint'(set_y[a]) - longint'(set_y[b]);
    return longint'(dx * dx) + longint'(dy * dy);
  endfunction

  // Adds one accepted point to the set and, on the final point, queues the path.
  task automatic add_point_and_build(point_t p);
    bit visited[CAPACITY];
    int cur, best, k, i;
    longint unsigned best_d, d;
    segment_t s;
    if (set_count < CAPACITY) begin
      set_x[set_count] = p.x;
      set_y[set_count] = p.y;
      set_count++;
    end else begin
      set_overflow = 1'b1;
    end
    if (!p.last) return;
    if (set_count >= 2) begin
      cur = 0;
      for (i = 1; i < set_count; i++)
        if (set_x[i] < set_x[cur]) cur = i;
      foreach (visited[j]) visited[j] = 1'b0;
      visited[cur] = 1'b1;
      for (k = 0; k + 1 < set_count; k++) begin
        best = -1;
        best_d = 0;
        for (i = 0; i < set_count; i++) begin
          if (visited[i]) continue;
          d = dist_sq(cur, i);
          if (best < 0 || d < best_d || (d == best_d && set_x[i] < set_x[best])) begin
            best = i;
            best_d = d;
          end
        end
        s.from_idx = cur[4:0];
        s.to_idx   = best[4:0];
        s.ovf      = set_overflow;
        s.last_seg = (k + 2 == set_count);
        expected_segments = {expected_segments, s};
        visited[best] = 1'b1;
        cur = best;
      end
      sets_built++;
    end
    set_count = 0;
    set_overflow = 1'b0;
  endtask

  function automatic point_t make_point(logic signed [15:0] x, logic signed [15:0] y,
                                        bit last);
    point_t p;
    p.x = x;
    p.y = y;
    p.last = last;
    return p;
  endfunction

  task automatic stage_point(point_t p);
    pending_points = {pending_points, p};
  endtask

  // Small coordinate range gives plenty of distance and x ties.
  task automatic queue_set(int n, bit narrow);
    int i;
    logic signed [15:0] x, y;
    for (i = 0; i < n; i++) begin
      if (narrow) begin
        x = 16'($signed($urandom_range(0, 6)) - 3);
        y = 16'($signed($urandom_range(0, 6)) - 3);
      end else begin
        x = 16'($urandom);
        y = 16'($urandom);
      end
      stage_point(make_point(x, y, i == n - 1));
    end
  endtask

  // The input handshake is taken at the rising edge and used by the driver.
  always @(posedge clk) begin
    in_fire <= rst_n && in_tvalid && in_tready;
  end

  // Driver: inputs change on the falling edge; an offered word stays until taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_fire) begin
        add_point_and_build({in_tdata[15:0], in_tdata[31:16], in_tlast});
        void'(pending_points.pop_front());
      end
      if (!(in_tvalid && !in_fire)) begin
        if (pending_points.size() > 0 && (calm_phase || hold_left > 0 ||
            $urandom_range(0, 99) >= 38)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= {pending_points[0].y, pending_points[0].x};
          in_tlast  <= pending_points[0].last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: ready also changes on the falling edge; a hold-off is counted here.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left <= 0;
    end else if (hold_request && hold_left == 0) begin
      hold_left <= 400;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= (hold_left == 1);
    end else begin
      out_tready <= calm_phase || ($urandom_range(0, 99) >= 38);
    end
  end

  // Monitor: sample outputs on the rising edge.
  always @(posedge clk) begin
    segment_t got, want;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[4:0], out_tdata[9:5], out_tdata[10], out_tlast};
      segments_seen <= segments_seen + 1;
      if (expected_segments.size() == 0) begin
        $display("%0t: unexpected segment %h, none expected", $time, got);
        errors <= errors + 1;
      end else begin
        want = expected_segments.pop_front();
        if (got.from_idx !== want.from_idx || got.to_idx !== want.to_idx ||
            got.ovf !== want.ovf || got.last_seg !== want.last_seg) begin
          $display({"%0t: segment mismatch expected from=%0d to=%0d ovf=%0b last=%0b,",
                    " actual from=%0d to=%0d ovf=%0b last=%0b"},
                   $time, want.from_idx, want.to_idx, want.ovf, want.last_seg,
                   got.from_idx, got.to_idx, got.ovf, got.last_seg);
          errors <= errors + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int s, n;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    errors = 0;
    cycles = 0;
    segments_seen = 0;
    sets_built = 0;
    set_count = 0;
    set_overflow = 1'b0;
    calm_phase = 1'b0;
    hold_request = 1'b0;
    hold_left = 0;
    stim_done = 1'b0;
    in_fire = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Directed: lone point, pair at the coordinate extremes, ties, equal points.
    stage_point(make_point(16'sh7fff, 16'sh8000, 1'b1));
    stage_point(make_point(16'sh7fff, 16'sh7fff, 1'b0));
    stage_point(make_point(16'sh8000, 16'sh8000, 1'b1));
    stage_point(make_point(16'sd0, 16'sd0, 1'b0));
    stage_point(make_point(16'sd0, 16'sd5, 1'b0));
    stage_point(make_point(16'sd3, 16'sd4, 1'b0));
    stage_point(make_point(-16'sd3, 16'sd4, 1'b0));
    stage_point(make_point(-16'sd3, -16'sd4, 1'b0));
    stage_point(make_point(16'sd3, 16'sd4, 1'b1));
    stage_point(make_point(16'sh5555, 16'shaaaa, 1'b0));
    stage_point(make_point(16'shaaaa, 16'sh5555, 1'b1));
    wait (pending_points.size() == 0 && expected_segments.size() == 0);

    // Overflow: a full store plus dropped points, the last one dropped too.
    // A second set follows so the input backs up behind the held output.
    queue_set(35, 1'b0);
    queue_set(5, 1'b0);
    hold_request = 1'b1;
    wait (hold_left > 0);
    hold_request = 1'b0;
    wait (pending_points.size() == 0 && expected_segments.size() == 0);

    // Random sets with a no-idle stretch in the middle.
    for (s = 0; s < 22; s++) begin
      calm_phase = (s >= 8 && s < 12);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 6);
      queue_set(n, $urandom_range(0, 1));
      wait (pending_points.size() == 0);
    end
    calm_phase = 1'b0;
    wait (pending_points.size() == 0 && expected_segments.size() == 0);
    repeat (200) @(posedge clk);

    $display("covered %0d path builds, %0d segments, overflow and tie cases",
             sets_built, segments_seen);
    if (errors == 0 && expected_segments.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
